// ----- sv/servo_pwm_with_deadband_defines.svh -----
// Assertion macros used by the top-level servo PWM design file.
`ifndef SERVO_PWM_WITH_DEADBAND_DEFINES_SVH
`define SERVO_PWM_WITH_DEADBAND_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define SPWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("servo PWM check failed");

// The antecedent implies the consequent in the following cycle.
`define SPWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("servo PWM check failed");

`endif

// ----- sv/spwm_pkg.sv -----
// Types and constants shared by the servo PWM generator.
package spwm_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int LIMIT_W = 15;
  localparam int WIDTH_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam logic [15:0] PERIOD_RESET = 16'd39999;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHANNEL_ENABLE = 3'd0,
    REG_MIN_WIDTH_A    = 3'd1,
    REG_MAX_WIDTH_A    = 3'd2,
    REG_MIN_WIDTH_B    = 3'd3,
    REG_MAX_WIDTH_B    = 3'd4,
    REG_DEADBAND       = 3'd5,
    REG_PERIOD_TOP     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]              enable;
    logic [1:0]              enable_rise;
    logic [1:0]              enable_fall;
    logic [1:0][LIMIT_W-1:0] min_width;
    logic [1:0][LIMIT_W-1:0] max_width;
    logic [WIDTH_W-1:0]      deadband;
    logic [WIDTH_W-1:0]      period_top;
  } cfg_t;

  typedef struct packed {
    logic               pwm_a;
    logic               pwm_b;
    logic               changed;
    logic [WIDTH_W-1:0] compare_ticks;
  } result_t;

endpackage

// ----- sv/servo_pwm_with_deadband.sv -----
// A request passes through the single input holding register, then the single result register.
// Throughput: one request per cycle, set by those registers, unless result_ready stalls.
// The tick counter is TIMER_WIDTH bits wide and wraps after period_top.
// Reset clears the counter, stored widths, compare values, valid flags and config
// registers; period_top resets to 39999. Held request and result data are not reset.
`include "servo_pwm_with_deadband_defines.svh"

module servo_pwm_with_deadband #(
  parameter int TIMER_WIDTH = spwm_pkg::TIMER_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [spwm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spwm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  logic                             opcode,
  input  logic                             channel,
  input  logic [spwm_pkg::WIDTH_W-1:0]     pulse_us,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic                             pwm_a,
  output logic                             pwm_b,
  output logic                             changed,
  output logic [spwm_pkg::WIDTH_W-1:0]     compare_ticks
);

  spwm_pkg::cfg_t               cfg;
  spwm_pkg::result_t            core_result;
  logic                         hold_valid;
  logic                         hold_opcode;
  logic                         hold_channel;
  logic [spwm_pkg::WIDTH_W-1:0] hold_pulse;
  logic                         fire;

  assign fire       = hold_valid && (!result_valid || result_ready);
  assign item_ready = !hold_valid || fire;

  spwm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  spwm_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .opcode   (hold_opcode),
    .channel  (hold_channel),
    .pulse_us (hold_pulse),
    .cfg      (cfg),
    .result   (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      hold_opcode  <= opcode;
      hold_channel <= channel;
      hold_pulse   <= pulse_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pwm_a         <= core_result.pwm_a;
      pwm_b         <= core_result.pwm_b;
      changed       <= core_result.changed;
      compare_ticks <= core_result.compare_ticks;
    end
  end

  `SPWM_ASSERT_IMP(a_compare_even, result_valid && changed, compare_ticks[0] == 1'b0)
  `SPWM_ASSERT_IMP(a_disabled_a_low, result_valid && !cfg.enable[0], !pwm_a)
  `SPWM_ASSERT_IMP(a_disabled_b_low, result_valid && !cfg.enable[1], !pwm_b)
  `SPWM_ASSERT_IMP(a_ready_when_free, !result_valid, item_ready)
  `SPWM_ASSERT_NXT(a_hold_kept, hold_valid && !fire, hold_valid)

endmodule

// ----- sv/spwm_cfg.sv -----
// Configuration registers and enable change detection.
module spwm_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [spwm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spwm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output spwm_pkg::cfg_t                   cfg
);

  logic [1:0]                                enable;
  logic [1:0][spwm_pkg::LIMIT_W-1:0]         min_width;
  logic [1:0][spwm_pkg::LIMIT_W-1:0]         max_width;
  logic [spwm_pkg::WIDTH_W-1:0]              deadband;
  logic [spwm_pkg::WIDTH_W-1:0]              period_top;
  logic                                      enable_write;

  assign enable_write = cfg_we &&
                        (cfg_index == spwm_pkg::CFG_INDEX_W'(spwm_pkg::REG_CHANNEL_ENABLE));

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= '0;
      min_width  <= '0;
      max_width  <= '0;
      deadband   <= '0;
      period_top <= spwm_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (spwm_pkg::cfg_reg_t'(cfg_index))
        spwm_pkg::REG_CHANNEL_ENABLE: enable       <= cfg_wdata[1:0];
        spwm_pkg::REG_MIN_WIDTH_A:    min_width[0] <= cfg_wdata[spwm_pkg::LIMIT_W-1:0];
        spwm_pkg::REG_MAX_WIDTH_A:    max_width[0] <= cfg_wdata[spwm_pkg::LIMIT_W-1:0];
        spwm_pkg::REG_MIN_WIDTH_B:    min_width[1] <= cfg_wdata[spwm_pkg::LIMIT_W-1:0];
        spwm_pkg::REG_MAX_WIDTH_B:    max_width[1] <= cfg_wdata[spwm_pkg::LIMIT_W-1:0];
        spwm_pkg::REG_DEADBAND:       deadband     <= cfg_wdata;
        spwm_pkg::REG_PERIOD_TOP:     period_top   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.enable      = enable;
    cfg.enable_rise = enable_write ? (cfg_wdata[1:0] & ~enable) : 2'b00;
    cfg.enable_fall = enable_write ? (~cfg_wdata[1:0] & enable) : 2'b00;
    cfg.min_width   = min_width;
    cfg.max_width   = max_width;
    cfg.deadband    = deadband;
    cfg.period_top  = period_top;
  end

endmodule

// ----- sv/spwm_core.sv -----
// Tick counter, per-channel width state and the single-pass result logic.
module spwm_core #(
  parameter int TIMER_WIDTH = spwm_pkg::TIMER_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic                         opcode,
  input  logic                         channel,
  input  logic [spwm_pkg::WIDTH_W-1:0] pulse_us,
  input  spwm_pkg::cfg_t               cfg,
  output spwm_pkg::result_t            result
);

  localparam int CW = (TIMER_WIDTH > spwm_pkg::WIDTH_W) ? TIMER_WIDTH : spwm_pkg::WIDTH_W;

  logic [TIMER_WIDTH-1:0]                 tick_counter;
  logic [TIMER_WIDTH-1:0]                 tick_counter_next;
  logic [1:0][spwm_pkg::WIDTH_W-1:0]      stored_width;
  logic [1:0][spwm_pkg::WIDTH_W-1:0]      compare_value;
  logic [1:0][spwm_pkg::WIDTH_W-1:0]      compare_next;
  logic [spwm_pkg::WIDTH_W-1:0]           min_sel;
  logic [spwm_pkg::WIDTH_W-1:0]           max_sel;
  logic [spwm_pkg::WIDTH_W-1:0]           clamped;
  logic [spwm_pkg::WIDTH_W-1:0]           diff;
  logic                                   is_tick;
  logic                                   write_ok;
  logic                                   take;

  assign is_tick  = (opcode == spwm_pkg::OP_TICK);
  assign min_sel  = spwm_pkg::WIDTH_W'(cfg.min_width[channel]);
  assign max_sel  = spwm_pkg::WIDTH_W'(cfg.max_width[channel]);
  assign write_ok = !is_tick && cfg.enable[channel];

  always_comb begin
    if (CW'(tick_counter) >= CW'(cfg.period_top)) begin
      tick_counter_next = '0;
    end else begin
      tick_counter_next = tick_counter + TIMER_WIDTH'(1);
    end
    if (!is_tick) begin
      tick_counter_next = tick_counter;
    end
  end

  always_comb begin
    if (pulse_us < min_sel) begin
      clamped = min_sel;
    end else if (pulse_us > max_sel) begin
      clamped = max_sel;
    end else begin
      clamped = pulse_us;
    end
    if (clamped >= stored_width[channel]) begin
      diff = clamped - stored_width[channel];
    end else begin
      diff = stored_width[channel] - clamped;
    end
    take = write_ok && (diff >= cfg.deadband);
    compare_next = compare_value;
    if (take) begin
      compare_next[channel] = {clamped[spwm_pkg::WIDTH_W-2:0], 1'b0};
    end
  end

  always_comb begin
    result.pwm_a = cfg.enable[0] && (CW'(tick_counter_next) <= CW'(compare_next[0]));
    result.pwm_b = cfg.enable[1] && (CW'(tick_counter_next) <= CW'(compare_next[1]));
    result.changed = take;
    result.compare_ticks = compare_next[channel];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter  <= '0;
      stored_width  <= '0;
      compare_value <= '0;
    end else begin
      if (fire) begin
        tick_counter  <= tick_counter_next;
        compare_value <= compare_next;
        if (take) begin
          stored_width[channel] <= clamped;
        end
      end
      for (int c = 0; c < 2; c++) begin
        if (cfg.enable_rise[c]) begin
          stored_width[c] <= spwm_pkg::WIDTH_W'(cfg.min_width[c]);
        end else if (cfg.enable_fall[c]) begin
          stored_width[c]  <= '0;
          compare_value[c] <= '0;
        end
      end
    end
  end

endmodule

// ----- sim/servo_pwm_with_deadband_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the two-channel servo PWM generator with clamping and deadband.
module servo_pwm_with_deadband_test;

  localparam logic [spwm_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic CH_A = 1'b0;
  localparam logic CH_B = 1'b1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int REQUESTS_PER_PHASE = 75;

  typedef struct packed {
    logic                             is_cfg;
    logic [spwm_pkg::CFG_INDEX_W-1:0] reg_index;
    logic [spwm_pkg::CFG_DATA_W-1:0]  wdata;
    spwm_pkg::op_t                    op;
    logic                             ch;
    logic [spwm_pkg::WIDTH_W-1:0]     pulse;
    logic                             typed;
    spwm_pkg::result_t                want;
  } plan_row_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [spwm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [spwm_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                             item_valid = 1'b0;
  logic                             item_ready;
  logic                             opcode = 1'b0;
  logic                             channel = 1'b0;
  logic [spwm_pkg::WIDTH_W-1:0]     pulse_us = '0;
  logic                             result_valid;
  logic                             result_ready = 1'b0;
  logic                             pwm_a;
  logic                             pwm_b;
  logic                             changed;
  logic [spwm_pkg::WIDTH_W-1:0]     compare_ticks;

  bit                sender_calm = 1'b0;
  bit                receiver_calm = 1'b0;
  int                stall_left = 0;
  int                cycle_count = 0;
  int                failures = 0;
  spwm_pkg::result_t pwm_outputs_due[$];
  spwm_pkg::result_t due;
  spwm_pkg::result_t got;

  logic [1:0]                           m_enable;
  logic [spwm_pkg::LIMIT_W-1:0]         m_min[2];
  logic [spwm_pkg::LIMIT_W-1:0]         m_max[2];
  logic [spwm_pkg::WIDTH_W-1:0]         m_deadband;
  logic [spwm_pkg::WIDTH_W-1:0]         m_period;
  logic [spwm_pkg::TIMER_WIDTH_DEF-1:0] m_counter;
  logic [spwm_pkg::WIDTH_W-1:0]         m_stored[2];
  logic [spwm_pkg::WIDTH_W-1:0]         m_compare[2];

  servo_pwm_with_deadband #(.TIMER_WIDTH(spwm_pkg::TIMER_WIDTH_DEF)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .opcode       (opcode),
    .channel      (channel),
    .pulse_us     (pulse_us),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pwm_a        (pwm_a),
    .pwm_b        (pwm_b),
    .changed      (changed),
    .compare_ticks(compare_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int idle_length(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic void apply_register_write(logic [spwm_pkg::CFG_INDEX_W-1:0] idx,
                                               logic [spwm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      spwm_pkg::REG_CHANNEL_ENABLE: begin
        for (int c = 0; c < 2; c++) begin
          if (!m_enable[c] && data[c]) begin
            m_stored[c] = spwm_pkg::WIDTH_W'(m_min[c]);
          end else if (m_enable[c] && !data[c]) begin
            m_stored[c] = '0;
            m_compare[c] = '0;
          end
        end
        m_enable = data[1:0];
      end
      spwm_pkg::REG_MIN_WIDTH_A: m_min[0] = data[spwm_pkg::LIMIT_W-1:0];
      spwm_pkg::REG_MAX_WIDTH_A: m_max[0] = data[spwm_pkg::LIMIT_W-1:0];
      spwm_pkg::REG_MIN_WIDTH_B: m_min[1] = data[spwm_pkg::LIMIT_W-1:0];
      spwm_pkg::REG_MAX_WIDTH_B: m_max[1] = data[spwm_pkg::LIMIT_W-1:0];
      spwm_pkg::REG_DEADBAND:    m_deadband = data;
      spwm_pkg::REG_PERIOD_TOP:  m_period = data;
      default: ;
    endcase
  endfunction

  function automatic spwm_pkg::result_t advance_servo(spwm_pkg::op_t op, logic ch,
                                                      logic [spwm_pkg::WIDTH_W-1:0] pulse);
    spwm_pkg::result_t            r;
    logic [spwm_pkg::WIDTH_W-1:0] w;
    logic [spwm_pkg::WIDTH_W-1:0] step_size;
    r = '0;
    if (op == spwm_pkg::OP_TICK) begin
      if (m_counter >= m_period) begin
        m_counter = '0;
      end else begin
        m_counter = m_counter + 1'b1;
      end
    end else if (m_enable[ch]) begin
      w = pulse;
      if (w < m_min[ch]) begin
        w = spwm_pkg::WIDTH_W'(m_min[ch]);
      end else if (w > m_max[ch]) begin
        w = spwm_pkg::WIDTH_W'(m_max[ch]);
      end
      step_size = (w >= m_stored[ch]) ? w - m_stored[ch] : m_stored[ch] - w;
      if (step_size >= m_deadband) begin
        m_stored[ch] = w;
        m_compare[ch] = {w[spwm_pkg::WIDTH_W-2:0], 1'b0};
        r.changed = 1'b1;
      end
    end
    r.pwm_a = m_enable[0] && (m_counter <= m_compare[0]);
    r.pwm_b = m_enable[1] && (m_counter <= m_compare[1]);
    r.compare_ticks = m_compare[ch];
    return r;
  endfunction

  function automatic logic [spwm_pkg::CFG_DATA_W-1:0] limit_value(bit wide);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      return {1'($urandom_range(0, 1)), 15'd0};
    end
    if (roll == 1) begin
      return {1'($urandom_range(0, 1)), 15'h7FFF};
    end
    return {1'($urandom_range(0, 1)), 15'(wide ? $urandom_range(0, 32767) : $urandom_range(0, 60))};
  endfunction

  function automatic plan_row_t cfg_row(logic [spwm_pkg::CFG_INDEX_W-1:0] idx,
                                        logic [spwm_pkg::CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_index = idx;
    row.wdata = data;
    return row;
  endfunction

  function automatic plan_row_t checked_row(spwm_pkg::op_t op, logic ch,
                                            logic [spwm_pkg::WIDTH_W-1:0] pulse,
                                            spwm_pkg::result_t want);
    plan_row_t row;
    row = '0;
    row.op = op;
    row.ch = ch;
    row.pulse = pulse;
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic plan_row_t item_row(spwm_pkg::op_t op, logic ch,
                                         logic [spwm_pkg::WIDTH_W-1:0] pulse);
    plan_row_t row;
    row = '0;
    row.op = op;
    row.ch = ch;
    row.pulse = pulse;
    return row;
  endfunction

  task automatic wait_for_idle();
    item_valid <= 1'b0;
    while (pwm_outputs_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [spwm_pkg::CFG_INDEX_W-1:0] idx,
                                logic [spwm_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_register_write(idx, data);
  endtask

  task automatic send_request(spwm_pkg::op_t op, logic ch, logic [spwm_pkg::WIDTH_W-1:0] pulse,
                              logic typed, spwm_pkg::result_t want);
    int                idle;
    logic              ready_seen;
    spwm_pkg::result_t r;
    idle = idle_length(sender_calm);
    cfg_we <= 1'b0;
    if (idle > 0) begin
      item_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode <= op;
    channel <= ch;
    pulse_us <= pulse;
    do begin
      @(negedge clk);
      ready_seen = item_ready;
      @(posedge clk);
    end while (!ready_seen);
    r = advance_servo(op, ch, pulse);
    pwm_outputs_due.push_back(typed ? want : r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      result_ready <= 1'b1;
      stall_left <= idle_length(receiver_calm);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (!rst && result_valid && result_ready) begin
      got = {pwm_a, pwm_b, changed, compare_ticks};
      if (pwm_outputs_due.size() == 0) begin
        $error("result arrived with no request outstanding");
        failures++;
      end else begin
        due = pwm_outputs_due.pop_front();
        if (got.pwm_a !== due.pwm_a) begin
          $error("pwm_a: expected %0d, actual %0d", due.pwm_a, got.pwm_a);
          failures++;
        end
        if (got.pwm_b !== due.pwm_b) begin
          $error("pwm_b: expected %0d, actual %0d", due.pwm_b, got.pwm_b);
          failures++;
        end
        if (got.changed !== due.changed) begin
          $error("changed: expected %0d, actual %0d", due.changed, got.changed);
          failures++;
        end
        if (got.compare_ticks !== due.compare_ticks) begin
          $error("compare_ticks: expected %0d, actual %0d", due.compare_ticks,
                 got.compare_ticks);
          failures++;
        end
      end
    end
  end

  initial begin
    plan_row_t                    plan[$];
    bit                           wide;
    bit                           enable_first;
    int                           roll;
    spwm_pkg::op_t                op;
    logic [1:0]                   en;
    logic [spwm_pkg::WIDTH_W-1:0] pulse;
    logic [spwm_pkg::WIDTH_W-1:0] band;
    logic [spwm_pkg::WIDTH_W-1:0] top;

    m_enable = '0;
    m_min = '{default: '0};
    m_max = '{default: '0};
    m_deadband = '0;
    m_period = spwm_pkg::PERIOD_RESET;
    m_counter = '0;
    m_stored = '{default: '0};
    m_compare = '{default: '0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    plan.push_back(checked_row(spwm_pkg::OP_TICK, CH_A, 16'd0, {1'b0, 1'b0, 1'b0, 16'd0}));
    plan.push_back(checked_row(spwm_pkg::OP_WRITE, CH_A, 16'hFFFF, {1'b0, 1'b0, 1'b0, 16'd0}));
    plan.push_back(checked_row(spwm_pkg::OP_WRITE, CH_B, 16'd0, {1'b0, 1'b0, 1'b0, 16'd0}));
    plan.push_back(cfg_row(spwm_pkg::REG_MIN_WIDTH_A, 16'd1000));
    plan.push_back(cfg_row(spwm_pkg::REG_MAX_WIDTH_A, 16'd2000));
    plan.push_back(cfg_row(spwm_pkg::REG_MIN_WIDTH_B, 16'd2000));
    plan.push_back(cfg_row(spwm_pkg::REG_MAX_WIDTH_B, 16'd1000));
    plan.push_back(cfg_row(spwm_pkg::REG_DEADBAND, 16'd0));
    plan.push_back(cfg_row(spwm_pkg::REG_CHANNEL_ENABLE, 16'd3));
    plan.push_back(checked_row(spwm_pkg::OP_WRITE, CH_A, 16'd0, {1'b1, 1'b0, 1'b1, 16'd2000}));
    plan.push_back(checked_row(spwm_pkg::OP_WRITE, CH_A, 16'hFFFF,
                               {1'b1, 1'b0, 1'b1, 16'd4000}));
    plan.push_back(checked_row(spwm_pkg::OP_WRITE, CH_B, 16'd1999,
                               {1'b1, 1'b1, 1'b1, 16'd4000}));
    plan.push_back(checked_row(spwm_pkg::OP_WRITE, CH_B, 16'd2000,
                               {1'b1, 1'b1, 1'b1, 16'd2000}));
    plan.push_back(item_row(spwm_pkg::OP_TICK, CH_B, 16'd0));
    plan.push_back(cfg_row(spwm_pkg::REG_DEADBAND, 16'd600));
    plan.push_back(item_row(spwm_pkg::OP_WRITE, CH_A, 16'd1500));
    plan.push_back(item_row(spwm_pkg::OP_WRITE, CH_A, 16'd1000));
    plan.push_back(item_row(spwm_pkg::OP_WRITE, CH_A, 16'd1600));
    plan.push_back(cfg_row(spwm_pkg::REG_DEADBAND, 16'hFFFF));
    plan.push_back(item_row(spwm_pkg::OP_WRITE, CH_A, 16'd2000));
    plan.push_back(cfg_row(spwm_pkg::REG_DEADBAND, 16'd0));
    plan.push_back(cfg_row(spwm_pkg::REG_PERIOD_TOP, 16'd2));
    plan.push_back(cfg_row(spwm_pkg::REG_MIN_WIDTH_A, 16'd0));
    plan.push_back(cfg_row(spwm_pkg::REG_MAX_WIDTH_A, 16'd0));
    plan.push_back(item_row(spwm_pkg::OP_WRITE, CH_A, 16'd0));
    plan.push_back(item_row(spwm_pkg::OP_TICK, CH_A, 16'd0));
    plan.push_back(item_row(spwm_pkg::OP_TICK, CH_A, 16'd0));
    plan.push_back(cfg_row(spwm_pkg::REG_PERIOD_TOP, 16'd0));
    plan.push_back(item_row(spwm_pkg::OP_TICK, CH_A, 16'd0));
    plan.push_back(item_row(spwm_pkg::OP_TICK, CH_B, 16'd0));
    plan.push_back(cfg_row(spwm_pkg::REG_CHANNEL_ENABLE, 16'd2));
    plan.push_back(item_row(spwm_pkg::OP_WRITE, CH_A, 16'd5));
    plan.push_back(cfg_row(spwm_pkg::REG_CHANNEL_ENABLE, 16'd2));
    plan.push_back(cfg_row(REG_UNUSED, 16'hFFFF));
    plan.push_back(cfg_row(spwm_pkg::REG_PERIOD_TOP, 16'hFFFF));
    plan.push_back(item_row(spwm_pkg::OP_TICK, CH_B, 16'd0));
    plan.push_back(cfg_row(spwm_pkg::REG_CHANNEL_ENABLE, 16'd3));
    plan.push_back(item_row(spwm_pkg::OP_WRITE, CH_A, 16'hFFFF));
    plan.push_back(item_row(spwm_pkg::OP_TICK, CH_A, 16'd0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_for_idle();
        write_register(plan[i].reg_index, plan[i].wdata);
      end else begin
        send_request(plan[i].op, plan[i].ch, plan[i].pulse, plan[i].typed, plan[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_idle();
      sender_calm = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      wide = ($urandom_range(0, 4) == 0);
      enable_first = 1'($urandom_range(0, 1));
      en = ($urandom_range(0, 9) < 7) ? 2'b11 : 2'($urandom_range(0, 3));
      roll = $urandom_range(0, 9);
      if (roll == 6) begin
        band = '0;
      end else if (roll == 7) begin
        band = 16'hFFFF;
      end else if (roll >= 8 && wide) begin
        band = 16'($urandom_range(0, 65535));
      end else begin
        band = 16'($urandom_range(0, 8));
      end
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        top = '0;
      end else if (roll == 1) begin
        top = 16'hFFFF;
      end else if (roll == 2) begin
        top = 16'd1;
      end else begin
        top = 16'(wide ? $urandom_range(1, 65535) : $urandom_range(2, 150));
      end
      if (enable_first) begin
        write_register(spwm_pkg::REG_CHANNEL_ENABLE, {14'($urandom_range(0, 16383)), en});
      end
      write_register(spwm_pkg::REG_MIN_WIDTH_A, limit_value(wide));
      write_register(spwm_pkg::REG_MAX_WIDTH_A, limit_value(wide));
      write_register(spwm_pkg::REG_MIN_WIDTH_B, limit_value(wide));
      write_register(spwm_pkg::REG_MAX_WIDTH_B, limit_value(wide));
      write_register(spwm_pkg::REG_DEADBAND, band);
      write_register(spwm_pkg::REG_PERIOD_TOP, top);
      if ($urandom_range(0, 4) == 0) begin
        write_register(REG_UNUSED, 16'($urandom_range(0, 65535)));
      end
      if (!enable_first) begin
        write_register(spwm_pkg::REG_CHANNEL_ENABLE, {14'($urandom_range(0, 16383)), en});
      end
      for (int k = 0; k < REQUESTS_PER_PHASE; k++) begin
        op = $urandom_range(0, 1) ? spwm_pkg::OP_WRITE : spwm_pkg::OP_TICK;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
          pulse = 16'hFFFF;
        end else if (roll == 1) begin
          pulse = '0;
        end else if (roll <= 3) begin
          pulse = 16'($urandom_range(0, 65535));
        end else begin
          pulse = 16'(wide ? $urandom_range(0, 32767) : $urandom_range(0, 80));
        end
        send_request(op, 1'($urandom_range(0, 1)), pulse, 1'b0, '0);
      end
    end

    wait_for_idle();
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
